[hdl/alif_pkg.sv]
// types, codes and constants shared by the adaptive lif neuron and its checker
// no dependencies

package alif_pkg;

  // input item of one tick
  typedef struct packed {
    logic signed [31:0] synaptic_input;
    logic signed [15:0] noise_sample;
  } in_item_t;

  // result item of one tick
  typedef struct packed {
    logic               spike;
    logic [1:0]         phase_out;
    logic signed [31:0] potential_out;
    logic [31:0]        threshold_out;
  } out_item_t;

  // neuron phase codes
  typedef enum logic [1:0] {
    PH_REST = 2'd0,
    PH_FIRE = 2'd1,
    PH_REFR = 2'd2
  } phase_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_NOISE,
    ST_DECIDE,
    ST_MUL_THR,
    ST_DIV,
    ST_LEAK_LD,
    ST_LEAK,
    ST_LEAK_FIN,
    ST_OUT
  } state_e;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_THR = 2'd0;
  localparam logic [1:0] CFG_RAISE    = 2'd1;
  localparam logic [1:0] CFG_LOWER    = 2'd2;

  localparam logic [31:0]        THR_RESET    = 32'd65536;
  localparam logic [15:0]        FACTOR_RESET = 16'd4096;
  localparam logic [15:0]        LEAK_Q16     = 16'd58982;
  localparam logic signed [31:0] POT_FLOOR    = -32'sd327680;

  // serial unit step counts
  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 44;
  localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

[hdl/adaptive_lif_neuron_step.sv]
// adaptive leaky integrate-and-fire neuron, one tick per input transfer
// depends on alif_pkg
//
//  channel | signals                            | transfer when
//  --------+------------------------------------+-------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i  | in_valid_i & in_ready_o
//  out     | out_valid_o, out_ready_i, out_data_o| out_valid_o & out_ready_i
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i   | cfg_we_i (no wait, no read-back)
//
// a tick runs from input transfer to the result register; its length differs at
// rest or firing, when entering refractory and when returning to rest, and is
// set by one shared bit-serial shift-add multiplier (16 steps, threshold raise
// and leak) and a bit-serial restoring divider (44 steps)
// reset: potential 0, phase resting, threshold 1.0, both factors 1.0
// a new tick is taken once the previous result has been moved into the
// output register; a stalled output holds the sequencer in its last state

module adaptive_lif_neuron_step import alif_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // saturating 32-bit signed add
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // control and architectural state
  state_e             state_q, state_d;
  phase_e             phase_q;
  logic signed [31:0] pot_q;
  logic [31:0]        thr_q;
  logic [15:0]        raise_q;
  logic [15:0]        lower_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;

  // working registers
  logic signed [31:0] syn_q;
  logic signed [15:0] noise_q;
  logic               spike_q;
  logic               neg_q;
  logic [31:0]        mcand_q;
  logic [47:0]        prod_q, prod_d;
  logic [15:0]        rem_q, rem_d;
  logic [43:0]        dvd_q, dvd_d;
  out_item_t          out_q;

  // sequencer strobes
  logic out_load;
  logic cnt_done;

  // serial multiplier step: multiplier bits sit in the low end of prod_q
  logic [32:0] mul_sum;
  always_comb begin
    mul_sum = {1'b0, prod_q[47:16]} + (prod_q[0] ? {1'b0, mcand_q} : 33'd0);
    prod_d  = {mul_sum, prod_q[15:1]};
  end

  // restoring divider step, quotient bits shift in from the right
  logic [16:0] div_r;
  logic [16:0] div_diff;
  logic        div_ge;
  always_comb begin
    div_r    = {rem_q, dvd_q[43]};
    div_diff = div_r - {1'b0, lower_q};
    div_ge   = div_r >= {1'b0, lower_q};
    rem_d    = div_ge ? div_diff[15:0] : div_r[15:0];
    dvd_d    = {dvd_q[42:0], div_ge};
  end

  // leak result: truncated magnitude, sign restored, clamped at the floor
  logic [31:0]        leak_mag;
  logic signed [31:0] leak_val;
  logic signed [31:0] leak_clamped;
  always_comb begin
    leak_mag     = prod_q[47:16];
    leak_val     = neg_q ? -$signed(leak_mag) : $signed(leak_mag);
    leak_clamped = (leak_val < POT_FLOOR) ? POT_FLOOR : leak_val;
  end

  // potential at or above threshold, signed against unsigned
  logic at_thr;
  assign at_thr = !pot_q[31] && ($unsigned(pot_q) >= thr_q);

  logic resting;
  assign resting = (phase_q != PH_FIRE) && (phase_q != PH_REFR);

  assign cnt_done = (cnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_ADD;
      ST_ADD:      state_d = ST_NOISE;
      ST_NOISE:    state_d = ST_DECIDE;
      ST_DECIDE: begin
        case (phase_q)
          PH_FIRE: state_d = ST_MUL_THR;
          PH_REFR: state_d = ST_DIV;
          default: state_d = ST_LEAK_LD;
        endcase
      end
      ST_MUL_THR:  if (cnt_done) state_d = ST_LEAK_LD;
      ST_DIV:      if (cnt_done) state_d = ST_LEAK_LD;
      ST_LEAK_LD:  state_d = ST_LEAK;
      ST_LEAK:     if (cnt_done) state_d = ST_LEAK_FIN;
      ST_LEAK_FIN: state_d = ST_OUT;
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // handshake outputs and strobes
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_REST;
      pot_q       <= '0;
      thr_q       <= THR_RESET;
      raise_q     <= FACTOR_RESET;
      lower_q     <= FACTOR_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes, expected only while no tick is in flight
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INIT_THR: thr_q   <= cfg_wdata_i;
          CFG_RAISE:    raise_q <= cfg_wdata_i[15:0];
          CFG_LOWER:    lower_q <= cfg_wdata_i[15:0];
          default:      ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_ADD:   pot_q <= sat_add(pot_q, syn_q);
        ST_NOISE: if (resting) pot_q <= sat_add(pot_q, {{16{noise_q[15]}}, noise_q});
        ST_DECIDE: begin
          case (phase_q)
            PH_FIRE: begin
              phase_q <= PH_REFR;
              cnt_q   <= CNT_W'(MUL_STEPS - 1);
            end
            PH_REFR: begin
              phase_q <= PH_REST;
              cnt_q   <= CNT_W'(DIV_STEPS - 1);
            end
            default: begin
              if (at_thr) begin
                phase_q <= PH_FIRE;
                pot_q   <= '0;
              end else begin
                phase_q <= PH_REST;
              end
            end
          endcase
        end
        ST_MUL_THR: begin
          cnt_q <= cnt_q - 1'b1;
          // last step: Q4.12 gain applied, saturate to 32 bits
          if (cnt_done) thr_q <= (prod_d[47:44] != '0) ? '1 : prod_d[43:12];
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          // zero divisor gives all ones and saturates the same way
          if (cnt_done) thr_q <= (dvd_d[43:32] != '0) ? '1 : dvd_d[31:0];
        end
        ST_LEAK_LD:  cnt_q <= CNT_W'(MUL_STEPS - 1);
        ST_LEAK:     cnt_q <= cnt_q - 1'b1;
        ST_LEAK_FIN: pot_q <= leak_clamped;
        default:     ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          syn_q   <= in_data_i.synaptic_input;
          noise_q <= in_data_i.noise_sample;
        end
      end
      ST_DECIDE: begin
        spike_q <= resting && at_thr;
        mcand_q <= thr_q;
        prod_q  <= {32'd0, raise_q};
        rem_q   <= '0;
        dvd_q   <= {thr_q, 12'd0};
      end
      ST_MUL_THR: prod_q <= prod_d;
      ST_DIV: begin
        rem_q <= rem_d;
        dvd_q <= dvd_d;
      end
      ST_LEAK_LD: begin
        // multiply the magnitude so the shift truncates toward zero
        neg_q   <= pot_q[31];
        mcand_q <= pot_q[31] ? $unsigned(-pot_q) : $unsigned(pot_q);
        prod_q  <= {32'd0, LEAK_Q16};
      end
      ST_LEAK: prod_q <= prod_d;
      ST_OUT: begin
        if (out_load) begin
          out_q.spike         <= spike_q;
          out_q.phase_out     <= phase_q;
          out_q.potential_out <= pot_q;
          out_q.threshold_out <= thr_q;
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/alif_checker.sv]
// port-level checks for adaptive_lif_neuron_step, attached by bind
// depends on alif_pkg

module alif_checker import alif_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // spike and firing phase go together
  a_spike_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.spike == (out_data_o.phase_out == PH_FIRE)))
    else $error("spike and firing phase disagree");

  // a spike zeroes the potential
  a_spike_pot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.spike |-> out_data_o.potential_out == '0)
    else $error("potential not zero on spike");

  // potential never below the floor
  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.potential_out >= POT_FLOOR)
    else $error("potential below floor");

  // one tick at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind adaptive_lif_neuron_step alif_checker u_alif_checker (.*);

[dv/tb_adaptive_lif_neuron_step.sv]
// self-checking testbench for adaptive_lif_neuron_step: directed and random ticks
// drives valid/ready channels with random gaps and checks each result against a
// cycle-free neuron predictor; depends on alif_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_adaptive_lif_neuron_step;
  import alif_pkg::*;

  // the slowest tick plus the output register fits within this, so it covers any leftover work
  localparam int SETTLE_CYCLES = 80;
  // ~530 ticks, with the limit set several times over their expected run length
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  adaptive_lif_neuron_step u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // neuron state and registers as the predictor sees them
  logic [15:0]        raise_reg;
  logic [15:0]        lower_reg;
  logic signed [31:0] nrn_pot;
  phase_e             nrn_phase;
  logic [31:0]        nrn_thr;

  out_item_t expected_ticks_q[$];
  out_item_t exp_tick;
  int        err_cnt;
  int        cycle_cnt;

  // idle percentages, changed per test phase
  int send_idle_pct;
  int recv_stall_pct;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] sat_s32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat_u32(longint v);
    if (v > longint'(64'h0000_0000_FFFF_FFFF)) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // one tick of the neuron: updates the state and returns the expected result
  function automatic out_item_t advance_neuron(in_item_t item);
    logic signed [31:0] pot;
    logic               resting;
    logic               fired;
    longint             prod;
    out_item_t          res;
    // the unused phase code behaves as resting
    resting = (nrn_phase != PH_FIRE) && (nrn_phase != PH_REFR);
    fired   = 1'b0;
    pot = sat_s32(longint'(nrn_pot) + longint'($signed(item.synaptic_input)));
    // noise only counts when resting at the start of the tick
    if (resting) pot = sat_s32(longint'(pot) + longint'($signed(item.noise_sample)));
    // signed potential against unsigned threshold, compared exactly
    if (resting && (longint'(pot) >= longint'({32'b0, nrn_thr}))) begin
      nrn_phase = PH_FIRE;
      fired     = 1'b1;
      pot       = '0;
    end else if (nrn_phase == PH_FIRE) begin
      nrn_phase = PH_REFR;
      nrn_thr   = sat_u32((longint'({32'b0, nrn_thr}) * longint'({48'b0, raise_reg})) >>> 12);
    end else if (nrn_phase == PH_REFR) begin
      nrn_phase = PH_REST;
      // a zero divisor yields all ones, like a restoring divider
      if (lower_reg == '0) nrn_thr = 32'hFFFF_FFFF;
      else nrn_thr = sat_u32((longint'({32'b0, nrn_thr}) <<< 12) / longint'({48'b0, lower_reg}));
    end else begin
      nrn_phase = PH_REST;
    end
    // leak by 0.9, truncating toward zero, then the -5.0 floor
    if (pot != 0) begin
      prod = (longint'(pot) * longint'({48'b0, LEAK_Q16})) / 64'sd65536;
      pot  = prod[31:0];
    end
    if (pot < POT_FLOOR) pot = POT_FLOOR;
    nrn_pot           = pot;
    res.spike         = fired;
    res.phase_out     = nrn_phase;
    res.potential_out = pot;
    res.threshold_out = nrn_thr;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // shared driving tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one input transfer; valid is left high so back-to-back ticks need no dip
  task automatic send_tick(input logic signed [31:0] syn, input logic signed [15:0] noise);
    in_item_t  item;
    out_item_t exp_new;
    item.synaptic_input = syn;
    item.noise_sample   = noise;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // transfer taken at this edge
    exp_new          = advance_neuron(item);
    expected_ticks_q = {expected_ticks_q, exp_new};
    @(negedge clk_i);
  endtask

  // stop sending, wait for every result, then let the sequencer go quiet
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (expected_ticks_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register writes, one per cycle, only while the block is idle
  task automatic write_regs(input logic [2:0] mask, input logic [31:0] thr,
                            input logic [15:0] raise_v, input logic [15:0] lower_v);
    if (mask[CFG_INIT_THR]) begin
      cfg_we_i     <= 1'b1;
      cfg_idx_i    <= CFG_INIT_THR;
      cfg_wdata_i  <= thr;
      nrn_thr       = thr; // writing the threshold reloads the adaptive one
      @(negedge clk_i);
    end
    if (mask[CFG_RAISE]) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_RAISE;
      cfg_wdata_i <= {16'b0, raise_v};
      raise_reg    = raise_v;
      @(negedge clk_i);
    end
    if (mask[CFG_LOWER]) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_LOWER;
      cfg_wdata_i <= {16'b0, lower_v};
      lower_reg    = lower_v;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and result checker
  // ---------------------------------------------------------------------------

  // random backpressure on the result channel
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: spike=%0b phase=%0d pot=%0d thr=%0d",
                             out_data_o.spike, out_data_o.phase_out,
                             out_data_o.potential_out, out_data_o.threshold_out));
      end else begin
        exp_tick = expected_ticks_q.pop_front();
        if (out_data_o.spike !== exp_tick.spike ||
            out_data_o.phase_out !== exp_tick.phase_out ||
            out_data_o.potential_out !== exp_tick.potential_out ||
            out_data_o.threshold_out !== exp_tick.threshold_out) begin
          note_error($sformatf({"tick mismatch: exp spike=%0b phase=%0d pot=%0d thr=%0d",
                                " | got spike=%0b phase=%0d pot=%0d thr=%0d"},
                               exp_tick.spike, exp_tick.phase_out,
                               exp_tick.potential_out, exp_tick.threshold_out,
                               out_data_o.spike, out_data_o.phase_out,
                               out_data_o.potential_out, out_data_o.threshold_out));
        end
      end
    end
  end

  // watchdog on total run length
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: resting, zero potential, threshold 1.0
  task automatic test_reset_state();
    send_tick(32'sd0, 16'sd0);
    send_tick(32'sh0000_8000, 16'sd0);
  endtask

  // rest -> fire -> refractory -> rest with default factors, plus noise extremes
  task automatic test_fire_cycle();
    send_tick(32'sh0001_0000, 16'sd0);
    send_tick(32'sd0, 16'sd0);
    send_tick(32'sd0, 16'sh7FFF);   // refractory at start, noise ignored
    send_tick(32'sd0, 16'sh7FFF);
    send_tick(32'sd0, -16'sh8000);
  endtask

  // saturating add at both ends, the -5.0 floor, and the exact compare boundary
  task automatic test_input_saturation();
    drain_and_settle();
    write_regs(3'b001, 32'hFFFF_FFFF, '0, '0);
    send_tick(32'sh7FFF_FFFF, 16'sh7FFF);
    send_tick(32'sh7FFF_FFFF, 16'sh7FFF);
    send_tick(-32'sh8000_0000, -16'sh8000);
    send_tick(-32'sh8000_0000, 16'sd0);
    drain_and_settle();
    write_regs(3'b001, 32'h0001_0000, '0, '0);
    // one below the threshold, then exactly on it
    send_tick(32'sh0000_FFFF - nrn_pot, 16'sd0);
    send_tick(32'sh0001_0000 - nrn_pot, 16'sd0);
    send_tick(32'sd0, 16'sd0);
    send_tick(32'sd0, 16'sd0);
  endtask

  // threshold raise and lower at their saturating ends and with a zero divisor
  task automatic test_threshold_adapt();
    drain_and_settle();
    write_regs(3'b111, 32'h4000_0000, 16'hFFFF, 16'h0001);
    send_tick(32'sh4000_0000 - nrn_pot, 16'sd0);
    send_tick(32'sd0, 16'sd0);        // product saturates
    send_tick(32'sd0, 16'sd0);        // quotient saturates
    drain_and_settle();
    // zero threshold fires at zero potential, zero gain, zero divisor
    write_regs(3'b111, 32'h0000_0000, 16'h0000, 16'h0000);
    send_tick(32'sd0, 16'sd0);
    send_tick(32'sd0, 16'sd0);
    send_tick(32'sd0, 16'sd0);
    drain_and_settle();
    write_regs(3'b111, 32'h7FFF_FFFF, FACTOR_RESET, 16'hFFFF);
    send_tick(32'sh7FFF_FFFF, 16'sd0);
    send_tick(32'sd0, 16'sd0);
    send_tick(32'sd0, 16'sd0);
  endtask

  // new register setting, with the extremes mixed in
  task automatic pick_config();
    logic [31:0] thr;
    logic [15:0] raise_v;
    logic [15:0] lower_v;
    case ($urandom_range(0, 9))
      0:       thr = 32'h0000_0000;
      1:       thr = 32'hFFFF_FFFF;
      2:       thr = $urandom;
      default: thr = $urandom_range(0, 32'h0008_0000);
    endcase
    case ($urandom_range(0, 7))
      0:       raise_v = 16'h0000;
      1:       raise_v = 16'hFFFF;
      2:       raise_v = 16'($urandom);
      default: raise_v = 16'($urandom_range(2048, 12288));
    endcase
    case ($urandom_range(0, 8))
      0:       lower_v = 16'h0000;
      1:       lower_v = 16'h0001;
      2:       lower_v = 16'hFFFF;
      3:       lower_v = 16'($urandom);
      default: lower_v = 16'($urandom_range(2048, 12288));
    endcase
    // mostly reload everything; sometimes keep the adapted threshold
    write_regs(($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b111,
               thr, raise_v, lower_v);
  endtask

  // random ticks, biased so the potential reaches the current threshold
  task automatic test_random_ticks(input int n_ticks);
    logic signed [31:0] syn;
    logic [31:0]        span;
    for (int i = 0; i < n_ticks; i++) begin
      if (i % 55 == 0) begin
        drain_and_settle();
        pick_config();
      end else if (i == n_ticks / 2 + 7) begin
        // hold the sender until the pipeline is empty
        drain_and_settle();
      end
      span = (nrn_thr > 32'h3000_0000) ? 32'h1000_0000 : (nrn_thr / 3) + 32'd1;
      case ($urandom_range(0, 9))
        0:       syn = $urandom;
        1:       syn = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
        2, 3:    syn = -$signed({1'b0, 31'($urandom_range(0, 32'h0002_0000))});
        default: syn = $urandom_range(0, span);
      endcase
      send_tick(syn, 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_INIT_THR;
    cfg_wdata_i    = '0;
    err_cnt        = 0;
    raise_reg      = FACTOR_RESET;
    lower_reg      = FACTOR_RESET;
    nrn_pot        = '0;
    nrn_phase      = PH_REST;
    nrn_thr        = THR_RESET;
    send_idle_pct  = 28;
    recv_stall_pct = 69;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender mostly busy, receiver mostly stalled
    test_reset_state();
    test_fire_cycle();
    test_input_saturation();
    test_threshold_adapt();
    test_random_ticks(167);

    // the other way round
    send_idle_pct  = 69;
    recv_stall_pct = 28;
    test_random_ticks(167);

    // full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_ticks(166);

    drain_and_settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_ticks_q.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_ticks_q.size()));
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
